### design/binary_isolated_pixel_cleanup_macros.svh
// Assertion macros shared by the isolated pixel cleanup modules.
`ifndef BINARY_ISOLATED_PIXEL_CLEANUP_MACROS_SVH
`define BINARY_ISOLATED_PIXEL_CLEANUP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BIPC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BIPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bipc_pkg.sv
// Shared constants, codes and types of the isolated pixel cleanup block.
package bipc_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 4096;
	localparam int MIN_DIM     = 3;
	localparam int PIX_W       = 8;
	localparam int FW_W        = 12;
	localparam int FH_W        = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int CNT_W       = 23;
	localparam int WU_W        = $clog2(MAX_WIDTH + 1);
	localparam int HU_W        = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int ADDR_W      = $clog2(MAX_WIDTH + 3);
	localparam int RAM_DEPTH   = 2 ** ADDR_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int NBR_N       = 8;
	localparam int NBR_W       = $clog2(NBR_N + 1);

	localparam logic [FW_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [FH_W-1:0]  HEIGHT_RESET = 13'd480;
	localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [PIX_W-1:0] PIX_BLACK    = '0;
	localparam logic [PIX_W-1:0] PIX_WHITE    = '1;
	localparam logic [NBR_W-1:0] FILL_BLACKS  = NBR_W'(7);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef struct packed {
		logic             is_data;
		logic             emit;
		logic             full;
		logic [PIX_W-1:0] pixel;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

endpackage

### design/binary_isolated_pixel_cleanup.sv
// Top level of the isolated pixel cleanup block: configuration registers and submodule wiring.
//
//   channel  handshake               payload
//   pix      pix_valid / pix_stall   opcode, pixel_in
//   res      res_valid / res_stall   pixel_out, changed, changed_count, frame_end
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is accepted per clock while the queue is not full; a result reaches the output register
// after its command passes the queue, the registered line memory reads and the output stage.
// Reset clears the counters, the pending count, the queue and all valid bits; the line
// memories are not cleared and hold no meaning until written.
// A stall on res freezes the window pipeline; the four-entry queue keeps pix open until full.
module binary_isolated_pixel_cleanup import bipc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [PIX_W-1:0]      pixel_out,
	output logic                  changed,
	output logic [CNT_W-1:0]      changed_count,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [WU_W-1:0] width_used;
	logic [HU_W-1:0] height_used;
	logic            push;
	logic            pop;
	cmd_t            push_cmd;
	cmd_t            pop_cmd;
	q_stat_t         q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[FW_W-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[FH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < FW_W'(MIN_DIM)) begin
			width_used = WU_W'(MIN_DIM);
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			width_used = WU_W'(MAX_WIDTH);
		end else begin
			width_used = WU_W'(frame_width_q);
		end
		if (frame_height_q < FH_W'(MIN_DIM)) begin
			height_used = HU_W'(MIN_DIM);
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			height_used = HU_W'(MAX_HEIGHT);
		end else begin
			height_used = HU_W'(frame_height_q);
		end
	end

	bipc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.width_used (width_used),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.opcode     (opcode),
		.pixel_in   (pixel_in),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	bipc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	bipc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.width_used    (width_used),
		.height_used   (height_used),
		.q_stat        (q_stat),
		.pop_cmd       (pop_cmd),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.pixel_out     (pixel_out),
		.changed       (changed),
		.changed_count (changed_count),
		.frame_end     (frame_end)
	);

endmodule

### design/bipc_front.sv
// Input side: accepts items, tracks pending pixels and classifies each item into a command.
module bipc_front import bipc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WU_W-1:0]  width_used,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  logic             opcode,
	input  logic [PIX_W-1:0] pixel_in,
	input  q_stat_t          q_stat,
	output logic             push,
	output cmd_t             push_cmd
);

	logic [ADDR_W-1:0] pending_q;
	logic [ADDR_W-1:0] pend_incl;
	logic [ADDR_W-1:0] width_p1;
	logic              accept;
	logic              is_data;
	logic              emit;
	logic              full;

	assign pix_stall = q_stat.full;
	assign accept    = pix_valid && !pix_stall;
	assign is_data   = (opcode == OP_PIXEL);
	assign width_p1  = ADDR_W'(width_used) + ADDR_W'(1);
	assign pend_incl = pending_q + ADDR_W'(is_data);
	assign full      = (pend_incl > width_p1);

	always_comb begin
		if (is_data) begin
			emit = full;
		end else begin
			emit = (pending_q != '0);
		end
	end

	assign push             = accept && (is_data || emit);
	assign push_cmd.is_data = is_data;
	assign push_cmd.emit    = emit;
	assign push_cmd.full    = full;
	assign push_cmd.pixel   = pixel_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept) begin
			pending_q <= pend_incl - ADDR_W'(emit);
		end
	end

endmodule

### design/bipc_queue.sv
// Short command queue between the input side and the window pipeline.
`include "binary_isolated_pixel_cleanup_macros.svh"
module bipc_queue import bipc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    pop_cmd,
	output q_stat_t q_stat
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign pop_cmd      = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.avail = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	`BIPC_ASSERT_IMPL(a_no_overflow, push && !pop, count_q != QCNT_W'(QUEUE_DEPTH), "command queue overflow")
	`BIPC_ASSERT_IMPL(a_no_underflow, pop, count_q != '0, "command queue read while empty")

endmodule

### design/bipc_back.sv
// Window pipeline: line memories, neighbor taps, cleanup rule, counters and output register.
`include "binary_isolated_pixel_cleanup_macros.svh"
module bipc_back import bipc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WU_W-1:0]  width_used,
	input  logic [HU_W-1:0]  height_used,
	input  q_stat_t          q_stat,
	input  cmd_t             pop_cmd,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic             changed,
	output logic [CNT_W-1:0] changed_count,
	output logic             frame_end
);

	logic [PIX_W-1:0]  rmem [RAM_DEPTH];
	logic [PIX_W-1:0]  fmem [RAM_DEPTH];

	logic [ADDR_W-1:0] rd_ptr_q;
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CNT_W-1:0]  flip_q;
	logic [PIX_W-1:0]  bot_q [2];
	logic [PIX_W-1:0]  top_q [2];
	logic [PIX_W-1:0]  left_q;

	logic              valid_s1;
	logic              full_s1;
	logic              interior_s1;
	logic              frame_end_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  bot_s1 [3];
	logic [PIX_W-1:0]  center_s1;
	logic [PIX_W-1:0]  right_s1;
	logic [PIX_W-1:0]  top_rd_s1;

	logic              valid_s2;
	logic [PIX_W-1:0]  pixel_s2;
	logic              changed_s2;
	logic [CNT_W-1:0]  count_s2;
	logic              frame_end_s2;

	logic              advance;
	logic              issue_emit;
	logic              issue_data;
	logic              s1_fire;
	logic [WU_W-1:0]   col_next;
	logic [HU_W-1:0]   row_next;
	logic              col_wrap;
	logic              row_wrap;
	logic              interior;
	logic [ADDR_W-1:0] right_addr;
	logic [ADDR_W-1:0] top_addr;
	logic [PIX_W-1:0]  nbr [NBR_N];
	logic [NBR_W-1:0]  blacks;
	logic              active;
	logic              flip;
	logic [PIX_W-1:0]  result;
	logic [CNT_W-1:0]  flip_sum;

	assign advance    = !(valid_s2 && res_stall);
	assign pop        = advance && q_stat.avail;
	assign issue_emit = pop && pop_cmd.emit;
	assign issue_data = pop && pop_cmd.is_data;
	assign s1_fire    = advance && valid_s1;

	assign col_next   = WU_W'(col_q) + WU_W'(1);
	assign row_next   = HU_W'(row_q) + HU_W'(1);
	assign col_wrap   = (col_next >= width_used);
	assign row_wrap   = (row_next >= height_used);
	assign interior   = (row_q != '0) && (row_next < height_used) &&
		(col_q != '0) && (col_next < width_used);
	assign right_addr = rd_ptr_q + ADDR_W'(1);
	assign top_addr   = rd_ptr_q - ADDR_W'(width_used) + ADDR_W'(1);

	// Received pixels, addressed by arrival position.
	always_ff @(posedge clk) begin
		if (issue_data) begin
			rmem[wr_ptr_q] <= pop_cmd.pixel;
		end
		if (advance) begin
			center_s1 <= rmem[rd_ptr_q];
			right_s1  <= rmem[right_addr];
		end
	end

	// Final pixel values, addressed by output position.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fmem[addr_s1] <= result;
		end
		if (advance) begin
			top_rd_s1 <= fmem[top_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue_data) begin
			bot_q[0] <= bot_q[1];
			bot_q[1] <= pop_cmd.pixel;
		end
		if (advance) begin
			full_s1      <= pop_cmd.full;
			interior_s1  <= interior;
			frame_end_s1 <= col_wrap && row_wrap;
			addr_s1      <= rd_ptr_q;
			bot_s1[0]    <= bot_q[0];
			bot_s1[1]    <= bot_q[1];
			bot_s1[2]    <= pop_cmd.pixel;
		end
		if (s1_fire) begin
			left_q       <= result;
			top_q[0]     <= top_q[1];
			top_q[1]     <= top_rd_s1;
			pixel_s2     <= result;
			changed_s2   <= flip;
			count_s2     <= flip_sum;
			frame_end_s2 <= frame_end_s1;
		end
	end

	always_comb begin
		nbr[0] = top_q[0];
		nbr[1] = top_q[1];
		nbr[2] = top_rd_s1;
		nbr[3] = left_q;
		nbr[4] = right_s1;
		nbr[5] = bot_s1[0];
		nbr[6] = bot_s1[1];
		nbr[7] = bot_s1[2];
		blacks = '0;
		for (int i = 0; i < NBR_N; i++) begin
			blacks = blacks + NBR_W'(nbr[i] == PIX_BLACK);
		end
	end

	assign active = full_s1 && interior_s1;

	always_comb begin
		if (center_s1 == PIX_BLACK) begin
			flip   = active && (blacks == '0);
			result = flip ? PIX_WHITE : center_s1;
		end else begin
			flip   = active && (blacks >= FILL_BLACKS);
			result = flip ? PIX_BLACK : center_s1;
		end
		if (flip && (flip_q != COUNT_MAX)) begin
			flip_sum = flip_q + CNT_W'(1);
		end else begin
			flip_sum = flip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			flip_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= issue_emit;
				valid_s2 <= valid_s1;
			end
			if (issue_data) begin
				wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
			end
			if (issue_emit) begin
				rd_ptr_q <= right_addr;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : ROW_W'(row_next);
				end else begin
					col_q <= COL_W'(col_next);
				end
			end
			if (s1_fire) begin
				flip_q <= frame_end_s1 ? '0 : flip_sum;
			end
		end
	end

	assign res_valid     = valid_s2;
	assign pixel_out     = pixel_s2;
	assign changed       = changed_s2;
	assign changed_count = count_s2;
	assign frame_end     = frame_end_s2;

	`BIPC_ASSERT_IMPL(a_flip_value, res_valid && changed, pixel_out == PIX_BLACK || pixel_out == PIX_WHITE, "flipped pixel is neither black nor white")
	`BIPC_ASSERT_NEXT(a_count_restart, res_valid && !res_stall && frame_end, !res_valid || changed_count == CNT_W'(changed), "flip count not restarted after frame end")
	`BIPC_ASSERT_IMPL(a_flush_has_pixel, pop && pop_cmd.emit && !pop_cmd.is_data, wr_ptr_q != rd_ptr_q, "flush output with no pending pixel")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the isolated pixel cleanup block with a scoreboard and random handshakes.
`timescale 1ns / 100ps

import bipc_pkg::*;

typedef struct packed {
	logic [PIX_W-1:0] pixel;
	logic             changed;
	logic [CNT_W-1:0] count;
	logic             frame_end;
} cleaned_pixel_t;

class cleanup_scoreboard;
	localparam int RING_LEN = 2 * MAX_WIDTH + 4;

	logic [FW_W-1:0]  width_reg;
	logic [FH_W-1:0]  height_reg;
	logic [PIX_W-1:0] ring [RING_LEN];
	int               head;
	int               waiting;
	int               col;
	int               row;
	logic [CNT_W-1:0] flips;
	cleaned_pixel_t   cleaned_q [$];
	int               errors;
	int               n_checked;
	int               n_flipped;
	int               n_frames;

	function new();
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		foreach (ring[i])
			ring[i] = '0;
		head = 0;
		waiting = 0;
		col = 0;
		row = 0;
		flips = '0;
		errors = 0;
		n_checked = 0;
		n_flipped = 0;
		n_frames = 0;
	endfunction

	function int used_width();
		if (width_reg < MIN_DIM)
			return MIN_DIM;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function int used_height();
		if (height_reg < MIN_DIM)
			return MIN_DIM;
		if (height_reg > MAX_HEIGHT)
			return MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function int waiting_pixels();
		return waiting;
	endfunction

	function int outstanding();
		return cleaned_q.size();
	endfunction

	function void note_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		if (idx == CFG_FRAME_WIDTH)
			width_reg = value[FW_W-1:0];
		else
			height_reg = value[FH_W-1:0];
	endfunction

	// Emits the oldest stored pixel. Neighbors behind it already hold final values.
	function void clean_oldest();
		int             w;
		int             h;
		int             dr;
		int             dc;
		int             blacks;
		bit             inner;
		cleaned_pixel_t r;
		w = used_width();
		h = used_height();
		r.pixel = ring[head];
		r.changed = 1'b0;
		r.frame_end = 1'b0;
		inner = row >= 1 && row + 1 < h && col >= 1 && col + 1 < w && waiting >= w + 2;
		if (inner) begin
			blacks = 0;
			for (dr = -1; dr <= 1; dr++) begin
				for (dc = -1; dc <= 1; dc++) begin
					if ((dr != 0 || dc != 0) &&
					    ring[(head + RING_LEN + dr * w + dc) % RING_LEN] == PIX_BLACK)
						blacks++;
				end
			end
			if (ring[head] == PIX_BLACK && blacks == 0) begin
				r.pixel = PIX_WHITE;
				r.changed = 1'b1;
			end else if (ring[head] != PIX_BLACK && blacks >= FILL_BLACKS) begin
				r.pixel = PIX_BLACK;
				r.changed = 1'b1;
			end
		end
		ring[head] = r.pixel;
		if (r.changed && flips != COUNT_MAX)
			flips++;
		r.count = flips;
		col++;
		if (col >= w) begin
			col = 0;
			if (row + 1 >= h) begin
				r.frame_end = 1'b1;
				row = 0;
			end else begin
				row++;
			end
		end
		if (r.frame_end)
			flips = '0;
		head = (head + 1) % RING_LEN;
		waiting--;
		cleaned_q = {cleaned_q, r};
	endfunction

	function void note_item(opcode_t op, logic [PIX_W-1:0] px);
		if (op == OP_PIXEL) begin
			ring[(head + waiting) % RING_LEN] = px;
			waiting++;
			if (waiting > used_width() + 1)
				clean_oldest();
		end else if (waiting > 0) begin
			clean_oldest();
		end
	endfunction

	function void check_cleaned(logic [PIX_W-1:0] px, logic chg, logic [CNT_W-1:0] cnt,
	                            logic fe);
		cleaned_pixel_t want;
		if (cleaned_q.size() == 0) begin
			$error("result transfer with no pixel waiting: pixel_out=%0d", px);
			errors++;
			return;
		end
		want = cleaned_q.pop_front();
		n_checked++;
		if (want.changed)
			n_flipped++;
		if (want.frame_end)
			n_frames++;
		if (px !== want.pixel) begin
			$error("pixel_out: expected %0d, actual %0d", want.pixel, px);
			errors++;
		end
		if (chg !== want.changed) begin
			$error("changed: expected %0d, actual %0d", want.changed, chg);
			errors++;
		end
		if (cnt !== want.count) begin
			$error("changed_count: expected %0d, actual %0d", want.count, cnt);
			errors++;
		end
		if (fe !== want.frame_end) begin
			$error("frame_end: expected %0d, actual %0d", want.frame_end, fe);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int N_PHASES      = 5;
	localparam int PHASE_W [N_PHASES]    = '{4, 7, 3, 12, 5};
	localparam int PHASE_H [N_PHASES]    = '{3, 5, 7, 4, 6};
	localparam int PHASE_GOAL [N_PHASES] = '{150, 190, 120, 190, 150};
	localparam int SEVEN_BLACK [9] = '{0, 0, 0, 0, 255, 0, 0, 0, 128};
	localparam int LONE_BLACK [9]  = '{255, 255, 1, 255, 0, 255, 255, 255, 255};

	logic                  clk;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_stall;
	logic                  opcode;
	logic [PIX_W-1:0]      pixel_in;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [PIX_W-1:0]      pixel_out;
	logic                  changed;
	logic [CNT_W-1:0]      changed_count;
	logic                  frame_end;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cleanup_scoreboard sb;
	bit                pix_calm;
	bit                res_calm;
	int                hold_left;
	int                n_pixels;
	int                n_flushes;
	int                n_geometries;

	wire pix_fire = pix_valid && !pix_stall;
	wire res_fire = res_valid && !res_stall;
	wire cfg_fire = cfg_valid && cfg_ready;

	binary_isolated_pixel_cleanup dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [PIX_W-1:0] draw_pixel(int black_pct);
		if ($urandom_range(0, 99) < black_pct)
			return PIX_BLACK;
		if ($urandom_range(0, 3) == 0)
			return PIX_WHITE;
		return PIX_W'($urandom_range(1, 255));
	endfunction

	task automatic send_item(input opcode_t op, input logic [PIX_W-1:0] px);
		int gap;
		if ($urandom_range(0, 79) == 0)
			pix_calm = !pix_calm;
		gap = pix_calm ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		opcode <= op;
		pixel_in <= px;
		do @(posedge clk); while (pix_stall);
		sb.note_item(op, px);
		if (op == OP_PIXEL)
			n_pixels++;
		else
			n_flushes++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.note_config(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drains every stored pixel and lets the block go quiet before the geometry changes.
	task automatic finish_phase();
		while (sb.waiting_pixels() > 0)
			send_item(OP_FLUSH, PIX_W'($urandom));
		if ($urandom_range(0, 1) == 0)
			send_item(OP_FLUSH, PIX_W'($urandom));
		@(negedge clk);
		pix_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_frames(input int item_goal, input int row_cap);
		int w;
		int h;
		int p;
		int first;
		int black_pct;
		int burst;
		w = sb.used_width();
		h = sb.used_height();
		if (row_cap != 0 && row_cap < h)
			h = row_cap;
		first = n_pixels + n_flushes;
		n_geometries++;
		do begin
			case ($urandom_range(0, 2))
				0: black_pct = 3;
				1: black_pct = 40;
				default: black_pct = 85;
			endcase
			for (p = 0; p < w * h; p++) begin
				if ($urandom_range(0, 59) == 0) begin
					burst = (w <= 16 && $urandom_range(0, 3) == 0) ? w + 3 :
					        $urandom_range(1, 8);
					repeat (burst) send_item(OP_FLUSH, PIX_W'($urandom));
				end
				send_item(OP_PIXEL, draw_pixel(black_pct));
			end
		end while (n_pixels + n_flushes - first < item_goal);
		finish_phase();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_fire) begin
			sb.check_cleaned(pixel_out, changed, changed_count, frame_end);
			if ($urandom_range(0, 79) == 0)
				res_calm = !res_calm;
			hold_left = res_calm ? 0 : $urandom_range(0, 14);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (pix_fire || res_fire || cfg_fire)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: no transfer for %0d cycles", QUIET_LIMIT);
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : stimulus
		int i;
		sb = new();
		pix_calm = 1'b0;
		res_calm = 1'b0;
		hold_left = 0;
		n_pixels = 0;
		n_flushes = 0;
		n_geometries = 0;
		pix_valid = 1'b0;
		opcode = OP_PIXEL;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A 3x3 frame: the center flips with seven black neighbors, then a frame whose
		// lone black center is flushed out early and must pass through unchanged.
		write_reg(CFG_FRAME_WIDTH, '0);
		write_reg(CFG_FRAME_HEIGHT, '0);
		n_geometries++;
		for (i = 0; i < 9; i++)
			send_item(OP_PIXEL, PIX_W'(SEVEN_BLACK[i]));
		for (i = 0; i < 5; i++)
			send_item(OP_PIXEL, PIX_W'(LONE_BLACK[i]));
		repeat (5) send_item(OP_FLUSH, PIX_W'($urandom));
		for (i = 5; i < 9; i++)
			send_item(OP_PIXEL, PIX_W'(LONE_BLACK[i]));
		finish_phase();

		for (i = 0; i < N_PHASES; i++) begin
			write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(PHASE_W[i]));
			write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(PHASE_H[i]));
			run_frames(PHASE_GOAL[i], 0);
		end

		// The tallest frame is only partly sent; nothing is configured after it.
		write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
		write_reg(CFG_FRAME_HEIGHT, '1);
		run_frames(1, 30);

		$display("tb_top: %0d pixel and %0d flush transfers over %0d frame geometries",
		         n_pixels, n_flushes, n_geometries);
		$display("tb_top: %0d results checked, %0d flipped, %0d frame ends",
		         sb.n_checked, sb.n_flipped, sb.n_frames);
		if (sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
